@@ design/tcfa_pkg.sv @@
// shared constants and types for the tilt complementary filter with alarm
// no dependencies
package tcfa_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [31:0] ANGLE_LIMIT = 32'sd5898240;
  localparam logic signed [31:0] HALF_TURN = 32'sd5898240;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // register indexes
  localparam logic [2:0] REG_BASE_PITCH = 3'd0;
  localparam logic [2:0] REG_BASE_ROLL = 3'd1;
  localparam logic [2:0] REG_THR_PITCH = 3'd2;
  localparam logic [2:0] REG_THR_ROLL = 3'd3;
  localparam logic [2:0] REG_BLEND = 3'd4;
  localparam logic [2:0] REG_WARMUP = 3'd5;

  // rounded atan(2^-i) in 1/32768 degree
  function automatic logic signed [21:0] atan_entry(input logic [4:0] i);
    logic signed [21:0] r;
    begin
      unique case (i)
        5'd0: r = 22'sd1474560;
        5'd1: r = 22'sd870484;
        5'd2: r = 22'sd459940;
        5'd3: r = 22'sd233473;
        5'd4: r = 22'sd117189;
        5'd5: r = 22'sd58652;
        5'd6: r = 22'sd29333;
        5'd7: r = 22'sd14667;
        5'd8: r = 22'sd7334;
        5'd9: r = 22'sd3667;
        5'd10: r = 22'sd1833;
        5'd11: r = 22'sd917;
        5'd12: r = 22'sd458;
        5'd13: r = 22'sd229;
        5'd14: r = 22'sd115;
        5'd15: r = 22'sd57;
        5'd16: r = 22'sd29;
        5'd17: r = 22'sd14;
        5'd18: r = 22'sd7;
        5'd19: r = 22'sd4;
        5'd20: r = 22'sd2;
        5'd21: r = 22'sd1;
        default: r = 22'sd0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic start;
    logic signed [25:0] y;
    logic signed [25:0] x;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [31:0] angle;
    logic signed [27:0] mag;
  } cordic_rsp_t;
endpackage

@@ design/tilt_complementary_filter_alarm.sv @@
// top level: tilt estimator with posture alarm, apb registers, stream ports
// depends on tcfa_pkg and tcfa_cordic
//
// a request runs the whole sequence below before the next is accepted. three
// passes go through the shared cordic unit, which answers a zero vector
// without rotating. the gain and magnitude steps do the gain correction. each
// axis then takes eight sequencer steps on one shared multiplier for gyro
// integration, the divide by 1000 and blending. the output step loads the
// result and the idle step takes the next request. s_tready is high only while
// the sequencer is idle. the result sits in an output register until it is
// taken, so a new request can start while it waits. the sequencer holds in its
// output step only while the previous result is still not taken. warm-up forces
// the alarm low for warmup_samples requests, min one; the last sets filter_ready.
module tilt_complementary_filter_alarm (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // accel_x, accel_y, accel_z, gyro_x_rate, gyro_y_rate, elapsed_ms
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pitch_angle, roll_angle
  output logic [31:0] m_tdata,
  // bad_posture, filter_ready
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_C1 = 4'd1;
  localparam logic [3:0] ST_GAIN = 4'd2;
  localparam logic [3:0] ST_C2 = 4'd3;
  localparam logic [3:0] ST_C3 = 4'd4;
  localparam logic [3:0] ST_INC = 4'd5;
  localparam logic [3:0] ST_DIV = 4'd6;
  localparam logic [3:0] ST_MA = 4'd7;
  localparam logic [3:0] ST_MB = 4'd8;
  localparam logic [3:0] ST_SAT = 4'd9;
  localparam logic [3:0] ST_OUT = 4'd10;
  localparam logic [3:0] ST_MAG = 4'd11;
  localparam logic [3:0] ST_QUO = 4'd12;
  localparam logic [3:0] ST_REM = 4'd13;
  localparam logic [3:0] ST_ADD = 4'd14;

  // ceil(2^38 / 125): exact floor(n / 125) for any n below 2^31
  localparam logic [31:0] DIV125_M = 32'd2199023256;

  logic [3:0] state;
  logic       axis;   // 0 pitch, 1 roll

  logic signed [15:0] baseline_pitch, baseline_roll;
  logic [14:0] pitch_limit, roll_limit;
  logic [15:0] blend_weight;
  logic [7:0]  warmup_samples;

  logic signed [23:0] pitch_estimate, roll_estimate;
  logic [7:0] warmup_count;
  logic       warmup_finished;

  logic signed [15:0] ax, ay, az, gx, gy;
  logic [15:0] ms;
  logic signed [27:0] mag;
  logic signed [31:0] acc_pitch, acc_roll;
  logic signed [47:0] prod;
  logic signed [47:0] sum;
  logic signed [34:0] inc;

  tcfa_pkg::cordic_req_t creq;
  tcfa_pkg::cordic_rsp_t crsp;

  tcfa_cordic u_cordic (.clk(clk), .rst(rst), .req(creq), .rsp(crsp));

  // apb
  logic wr_en;
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_pitch <= '0;
      baseline_roll <= '0;
      pitch_limit <= 15'd1280;
      roll_limit <= 15'd1280;
      blend_weight <= 16'd62259;
      warmup_samples <= 8'd50;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        tcfa_pkg::REG_BASE_PITCH: baseline_pitch <= pwdata[15:0];
        tcfa_pkg::REG_BASE_ROLL: baseline_roll <= pwdata[15:0];
        tcfa_pkg::REG_THR_PITCH: pitch_limit <= pwdata[14:0];
        tcfa_pkg::REG_THR_ROLL: roll_limit <= pwdata[14:0];
        tcfa_pkg::REG_BLEND: blend_weight <= pwdata[15:0];
        tcfa_pkg::REG_WARMUP: warmup_samples <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      tcfa_pkg::REG_BASE_PITCH: prdata = 32'(baseline_pitch);
      tcfa_pkg::REG_BASE_ROLL: prdata = 32'(baseline_roll);
      tcfa_pkg::REG_THR_PITCH: prdata = 32'(pitch_limit);
      tcfa_pkg::REG_THR_ROLL: prdata = 32'(roll_limit);
      tcfa_pkg::REG_BLEND: prdata = 32'(blend_weight);
      tcfa_pkg::REG_WARMUP: prdata = 32'(warmup_samples);
      default: prdata = '0;
    endcase
  end

  // shared multiplier operands, chosen by step
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [31:0] integ;
  logic signed [31:0] acc_sel;
  logic signed [23:0] est_sel;
  logic signed [15:0] rate_sel;
  assign est_sel = axis ? roll_estimate : pitch_estimate;
  assign rate_sel = axis ? gy : gx;
  assign acc_sel = axis ? acc_roll : acc_pitch;
  assign integ = 32'(est_sel) + 32'(inc);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_GAIN: begin mul_a = 32'(mag); mul_b = 18'(tcfa_pkg::INV_GAIN_Q16); end
      ST_INC: begin mul_a = 32'(rate_sel); mul_b = 18'({1'b0, ms}); end
      ST_MA: begin mul_a = integ; mul_b = 18'({1'b0, blend_weight}); end
      ST_MB: begin mul_a = acc_sel; mul_b = 18'(17'd65536 - 17'(blend_weight)); end
      default: ;
    endcase
  end

  // truncating divide of rate*ms*512 by 1000, i.e. rate*ms*64/125
  // |n| = 125*q + r, so |n|*64/125 = 64*q + floor(64*r/125)
  // q by reciprocal multiply, the small term by ceil(2^20/125)
  logic [30:0] pabs;
  logic [30:0] nabs;
  logic        inc_neg;
  logic [62:0] qfull;
  logic [24:0] qa;
  logic [30:0] qa125;
  logic [6:0]  rb;
  logic [26:0] fprod;
  logic [30:0] inc_mag;
  assign pabs = prod[47] ? 31'(-prod) : 31'(prod);
  assign qfull = {32'd0, nabs} * {31'd0, DIV125_M};
  assign qa125 = 31'(qa) * 31'd125;
  assign rb = 7'(nabs - qa125);
  assign fprod = 27'({rb, 6'b000000}) * 27'd8389;
  assign inc_mag = {qa, 6'b000000} + 31'(fprod[26:20]);

  logic signed [31:0] blended;
  logic signed [31:0] sat;
  assign blended = 32'(sum >>> 16);
  assign sat = (blended > tcfa_pkg::ANGLE_LIMIT) ? tcfa_pkg::ANGLE_LIMIT :
               (blended < -tcfa_pkg::ANGLE_LIMIT) ? -tcfa_pkg::ANGLE_LIMIT : blended;

  // alarm on the outputs in 1/128 degree
  logic signed [15:0] p_out, r_out;
  logic signed [17:0] dp, dr;
  logic [17:0] adp, adr;
  logic bad;
  assign p_out = 16'(pitch_estimate >>> 8);
  assign r_out = 16'(roll_estimate >>> 8);
  assign dp = 18'(p_out) - 18'(baseline_pitch);
  assign dr = 18'(r_out) - 18'(baseline_roll);
  assign adp = dp[17] ? 18'(-dp) : 18'(dp);
  assign adr = dr[17] ? 18'(-dr) : 18'(dr);
  assign bad = (adp > 18'(pitch_limit)) || (adr > 18'(roll_limit));

  logic [7:0] cnt_next;
  assign cnt_next = warmup_count + 1'b1;
  logic [7:0] wmin;
  assign wmin = (warmup_samples == 0) ? 8'd1 : warmup_samples;

  // output register free for a new result
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      pitch_estimate <= '0;
      roll_estimate <= '0;
      warmup_count <= '0;
      warmup_finished <= 1'b0;
      creq.start <= 1'b0;
      axis <= 1'b0;
    end else begin
      creq.start <= 1'b0;
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            ax <= s_tdata[15:0];
            ay <= s_tdata[31:16];
            az <= s_tdata[47:32];
            gx <= s_tdata[63:48];
            gy <= s_tdata[79:64];
            ms <= s_tdata[95:80];
            creq.start <= 1'b1;
            creq.y <= 26'(signed'(s_tdata[15:0])) <<< 8;
            creq.x <= 26'(signed'(s_tdata[47:32])) <<< 8;
            state <= ST_C1;
          end
        end
        ST_C1: if (crsp.done) begin
          mag <= crsp.mag;
          state <= ST_GAIN;
        end
        // product of the gain correction is registered and read in the magnitude step
        ST_GAIN: state <= ST_MAG;
        ST_MAG: begin
          creq.start <= 1'b1;
          creq.y <= 26'(ay) <<< 8;
          creq.x <= 26'(prod >>> 16);
          state <= ST_C2;
        end
        ST_C2: if (crsp.done) begin
          acc_pitch <= crsp.angle;
          creq.start <= 1'b1;
          creq.y <= -(26'(ax) <<< 8);
          creq.x <= 26'(az) <<< 8;
          state <= ST_C3;
        end
        ST_C3: if (crsp.done) begin
          acc_roll <= crsp.angle;
          axis <= 1'b0;
          state <= ST_INC;
        end
        ST_INC: state <= ST_DIV;
        ST_DIV: begin
          nabs <= pabs;
          inc_neg <= prod[47];
          state <= ST_QUO;
        end
        ST_QUO: begin
          qa <= qfull[62:38];
          state <= ST_REM;
        end
        ST_REM: begin
          inc <= inc_neg ? -(35'(inc_mag)) : 35'(inc_mag);
          state <= ST_MA;
        end
        ST_MA: state <= ST_MB;
        ST_MB: begin
          sum <= prod;
          state <= ST_ADD;
        end
        ST_ADD: begin
          sum <= sum + prod;
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (axis) begin
            roll_estimate <= 24'(sat);
            state <= ST_OUT;
          end else begin
            pitch_estimate <= 24'(sat);
            axis <= 1'b1;
            state <= ST_INC;
          end
        end
        ST_OUT: if (out_free) begin
          m_tdata <= {r_out, p_out};
          if (!warmup_finished) begin
            warmup_count <= cnt_next;
            warmup_finished <= (cnt_next >= wmin);
            m_tuser <= {(cnt_next >= wmin), 1'b0};
          end else begin
            m_tuser <= {1'b1, bad};
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // registered product of the shared multiplier
  always_ff @(posedge clk) begin
    prod <= 48'(mul_a) * 48'(mul_b);
  end
endmodule

@@ design/tcfa_cordic.sv @@
// shared cordic vectoring unit: one rotation per cycle, atan2 and magnitude
// depends on tcfa_pkg
module tcfa_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  tcfa_pkg::cordic_req_t req,
  output tcfa_pkg::cordic_rsp_t rsp
);
  logic                          busy;
  logic [tcfa_pkg::CNT_W-1:0]    step;
  logic signed [27:0]            x;
  logic signed [27:0]            y;
  logic signed [31:0]            z;
  logic signed [27:0]            dx;
  logic signed [27:0]            dy;
  logic signed [21:0]            at;
  logic signed [31:0]            zc;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = tcfa_pkg::atan_entry(5'(step));
  // clamp to half a turn
  assign zc = (z > tcfa_pkg::ANGLE_LIMIT) ? tcfa_pkg::ANGLE_LIMIT :
              (z < -tcfa_pkg::ANGLE_LIMIT) ? -tcfa_pkg::ANGLE_LIMIT : z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        step <= '0;
        if (req.x == 0 && req.y == 0) begin
          rsp.done <= 1'b1;
          rsp.angle <= '0;
          rsp.mag <= '0;
        end else begin
          busy <= 1'b1;
          if (req.x < 0) begin
            x <= -28'(req.x);
            y <= -28'(req.y);
            z <= (req.y >= 0) ? 32'(tcfa_pkg::HALF_TURN) : -32'(tcfa_pkg::HALF_TURN);
          end else begin
            x <= 28'(req.x);
            y <= 28'(req.y);
            z <= '0;
          end
        end
      end else if (busy) begin
        if (step == tcfa_pkg::CNT_W'(tcfa_pkg::CORDIC_STEPS)) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.angle <= zc;
          rsp.mag <= x;
        end else begin
          step <= step + 1'b1;
          if (y >= 0) begin
            x <= x + dx;
            y <= y - dy;
            z <= z + 32'(at);
          end else begin
            x <= x - dx;
            y <= y + dy;
            z <= z - 32'(at);
          end
        end
      end
    end
  end
endmodule
